/* src/framed_command_packet_parser_defines.svh */
// Assertion macros for the framed command packet parser.
// Included by the top level; expects clk and rst_n in scope.
`ifndef FRAMED_COMMAND_PACKET_PARSER_DEFINES_SVH
`define FRAMED_COMMAND_PACKET_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define FCPP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framed command packet parser assertion failed");
`define FCPP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framed command packet parser assertion failed");
`else
`define FCPP_ASSERT_IMP(label, ante, cons)
`define FCPP_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* src/fcpp_pkg.sv */
// Shared types and constants for the framed command packet parser.
// No dependencies.
package fcpp_pkg;

    localparam logic [15:0] TimeoutReset    = 16'd50;
    localparam logic [7:0]  SyncFirstReset  = 8'hFF;
    localparam logic [7:0]  SyncSecondReset = 8'hAA;
    localparam logic [7:0]  CaseFold        = 8'd32;
    localparam logic [15:0] IdleMax         = 16'hFFFF;
    localparam int          PayloadLen      = 5;

    localparam logic [1:0] CfgTimeout    = 2'd0;
    localparam logic [1:0] CfgSyncFirst  = 2'd1;
    localparam logic [1:0] CfgSyncSecond = 2'd2;

    localparam logic [2:0] PosIdle    = 3'd0;
    localparam logic [2:0] PosSync    = 3'd1;
    localparam logic [2:0] PosPayload = 3'd2;
    localparam logic [2:0] PosCheck   = 3'd7;

    localparam logic ReqByte = 1'b0;
    localparam logic ReqTick = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_value;
        logic       burst_start;
    } req_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] arg_zero;
        logic [7:0] arg_one;
        logic [7:0] arg_two;
        logic [7:0] arg_three;
        logic       from_text;
    } rsp_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
    } cfg_t;

endpackage

/* src/framed_command_packet_parser.sv */
// Usage: framed command packet parser.
// Request channel (req_valid, req_stall, req) carries one word per received
// byte or millisecond tick. Response channel (rsp_valid, rsp_stall, rsp)
// carries one word per accepted command: a text command or a binary frame
// whose checksum matched. Configuration writes use cfg_valid/cfg_ready with
// cfg_index 0 = timeout_ms, 1 = sync_first, 2 = sync_second; other indexes
// are ignored. cfg_ready is always high.
// A request word is held in an input register, then parsed combinationally
// into the response register. One request word is taken every cycle while
// the response side keeps up; the single parse step is the only work per word.
// Reset clears the frame position, checksum, idle counter and the valid flags
// of both pipeline registers, and restores the configuration defaults.
// When the receiver stalls, the response word holds and the input register
// keeps one more word; req_stall then rises until the response is taken.
// Depends on fcpp_pkg, fcpp_cfg_regs, fcpp_parse_core and the defines header.
`include "framed_command_packet_parser_defines.svh"
module framed_command_packet_parser
    import fcpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic s1_valid_reg;
    logic s1_valid_next;
    req_t s1_item_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;

    logic out_free;
    logic step;
    logic accept;
    logic res_valid;
    rsp_t res;
    cfg_t cfg;
    logic text_args_zero;

    assign cfg_ready = 1'b1;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign step      = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;

    fcpp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fcpp_parse_core u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (s1_item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        rsp_valid_next = out_free ? res_valid : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= req;
        end
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign text_args_zero = (rsp.arg_zero == 8'd0) && (rsp.arg_one == 8'd0)
                            && (rsp.arg_two == 8'd0) && (rsp.arg_three == 8'd0);

    `FCPP_ASSERT_IMP(a_stall_needs_item, req_stall, s1_valid_reg && rsp_valid_reg)
    `FCPP_ASSERT_NXT(a_held_item_kept, s1_valid_reg && !out_free, s1_valid_reg)
    `FCPP_ASSERT_IMP(a_text_args_zero, rsp_valid && rsp.from_text, text_args_zero)
    `FCPP_ASSERT_NXT(a_result_lands, res_valid, rsp_valid_reg)

endmodule

/* src/fcpp_cfg_regs.sv */
// Configuration register file of the framed command packet parser.
// Depends on fcpp_pkg.
module fcpp_cfg_regs
    import fcpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CfgTimeout:    cfg_next.timeout_ms  = wr_data;
                CfgSyncFirst:  cfg_next.sync_first  = wr_data[7:0];
                CfgSyncSecond: cfg_next.sync_second = wr_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms  <= TimeoutReset;
            cfg_reg.sync_first  <= SyncFirstReset;
            cfg_reg.sync_second <= SyncSecondReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/fcpp_parse_core.sv */
// Parser state and single-step frame logic of the framed command packet parser.
// Depends on fcpp_pkg.
module fcpp_parse_core
    import fcpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t item,
    input  cfg_t cfg,
    output logic res_valid,
    output rsp_t res
);

    logic [2:0]  pos_reg;
    logic [2:0]  pos_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [15:0] idle_reg;
    logic [15:0] idle_next;
    logic [7:0]  bytes_reg [PayloadLen];

    logic [2:0] pos_eff;
    logic [7:0] b;
    logic       is_text;
    logic       is_lower;

    assign b        = item.byte_value;
    assign is_lower = (b >= "a") && (b <= "z");
    assign is_text  = ((b >= "A") && (b <= "Z")) || is_lower || ((b >= "0") && (b <= "9"));

    always_comb
    begin
        pos_eff   = pos_reg;
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        idle_next = idle_reg;
        res_valid = 1'b0;
        res       = '0;
        if (item.req_type == ReqTick)
        begin
            if (idle_reg != IdleMax)
            begin
                idle_next = idle_reg + 16'd1;
            end
        end
        else
        begin
            if (item.burst_start)
            begin
                if (idle_reg > cfg.timeout_ms)
                begin
                    pos_eff = PosIdle;
                end
                idle_next = '0;
            end
            pos_next = pos_eff;
            if (pos_eff == PosIdle)
            begin
                if (is_text)
                begin
                    res_valid     = 1'b1;
                    res.command   = is_lower ? (b - CaseFold) : b;
                    res.from_text = 1'b1;
                end
                else if (b == cfg.sync_first)
                begin
                    pos_next = PosSync;
                end
            end
            else if (pos_eff == PosSync)
            begin
                if (b == cfg.sync_second)
                begin
                    pos_next = PosPayload;
                    sum_next = '0;
                end
                else
                begin
                    pos_next = PosIdle;
                end
            end
            else if (pos_eff != PosCheck)
            begin
                sum_next = sum_reg + b;
                pos_next = pos_eff + 3'd1;
            end
            else
            begin
                pos_next = PosIdle;
                if (b == sum_reg)
                begin
                    res_valid     = 1'b1;
                    res.command   = bytes_reg[0];
                    res.arg_zero  = bytes_reg[1];
                    res.arg_one   = bytes_reg[2];
                    res.arg_two   = bytes_reg[3];
                    res.arg_three = bytes_reg[4];
                    res.from_text = 1'b0;
                end
            end
        end
        if (!step)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= PosIdle;
            sum_reg  <= '0;
            idle_reg <= '0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            idle_reg <= idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PayloadLen; i++)
        begin
            if (step && (item.req_type == ReqByte) && (pos_eff == (PosPayload + 3'(i))))
            begin
                bytes_reg[i] <= b;
            end
        end
    end

endmodule
